/* hdl/cse_pkg.sv */
`default_nettype none
package cse_pkg;
	localparam int VALUE_RANGE = 1024;
	localparam int CAPACITY    = 1024;
	localparam int VALUE_W     = 10;
	localparam int BIN_W       = $clog2(VALUE_RANGE);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_TAKE   = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_INS  = 4'b0100,
		ST_TAKE = 4'b1000
	} state_t;
endpackage
`default_nettype wire

/* hdl/counting_sort_engine_core.sv */
// Insert: accepted when idle, then busy for the read-modify-write of its bin.
// Take: busy while it reads bins from the scan cursor through
// the first non-zero bin (one bin per cycle through the single RAM read port).
// The result word strobes on done in the cycle after it is found; an empty take
// gives its word the cycle after acceptance. The receiver cannot stall.
// After reset the block sweeps the bin RAM to zero, busy until the sweep ends.
`default_nettype none
module counting_sort_engine_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        cmd,
	input  wire logic [cse_pkg::VALUE_W-1:0] value,
	output logic                             done,
	output logic      [cse_pkg::VALUE_W-1:0] sorted_value,
	output logic                             empty_res,
	output logic                             last
);
	import cse_pkg::*;

	state_t           state_q;
	logic [BIN_W-1:0] clr_q;
	logic [BIN_W-1:0] cursor_q;
	logic [BIN_W-1:0] chk_q;
	logic [BIN_W-1:0] ins_addr_q;
	logic [CNT_W-1:0] total_q;

	logic             wr_en;
	logic [BIN_W-1:0] wr_addr;
	logic [CNT_W-1:0] wr_data;
	logic [BIN_W-1:0] rd_addr;
	logic [CNT_W-1:0] rd_data;

	logic accept;
	logic in_range;
	logic is_take;
	logic found;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign is_take  = (cmd_t'(cmd) == CMD_TAKE);
	assign in_range = (32'(value) < VALUE_RANGE);
	assign found    = (state_q == ST_TAKE) && (rd_data != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_addr = BIN_W'(value);
		unique case (state_q)
			ST_CLR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				if (is_take) begin
					rd_addr = cursor_q;
				end
			end
			ST_INS: begin
				wr_en   = 1'b1;
				wr_addr = ins_addr_q;
				wr_data = rd_data + 1'b1;
			end
			ST_TAKE: begin
				rd_addr = chk_q + 1'b1;
				wr_en   = found;
				wr_addr = chk_q;
				wr_data = rd_data - 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	cse_ram #(
		.WIDTH(CNT_W),
		.DEPTH(VALUE_RANGE)
	) u_bins (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			cursor_q <= '0;
			total_q  <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_W'(VALUE_RANGE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (is_take) begin
							if (total_q == '0) begin
								done <= 1'b1;
							end else begin
								state_q <= ST_TAKE;
							end
						end else if (in_range && (32'(total_q) < CAPACITY)) begin
							total_q <= total_q + 1'b1;
							state_q <= ST_INS;
							if (BIN_W'(value) < cursor_q) begin
								cursor_q <= BIN_W'(value);
							end
						end
					end
				end
				ST_INS: begin
					state_q <= ST_IDLE;
				end
				ST_TAKE: begin
					if (found) begin
						total_q  <= total_q - 1'b1;
						cursor_q <= chk_q;
						done     <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			chk_q      <= cursor_q;
			ins_addr_q <= BIN_W'(value);
		end else if (state_q == ST_TAKE) begin
			chk_q <= chk_q + 1'b1;
		end
		if (accept && is_take && (total_q == '0)) begin
			sorted_value <= '0;
			empty_res    <= 1'b1;
			last         <= 1'b0;
		end else if (found) begin
			sorted_value <= VALUE_W'(chk_q);
			empty_res    <= 1'b0;
			last         <= (total_q == CNT_W'(1));
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= CAPACITY)
		else $error("stored count exceeds capacity");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_take && (total_q == '0) |=> done && empty_res)
		else $error("empty take gave no empty word");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_TAKE) || $past(state_q == ST_IDLE))
		else $error("result word from wrong state");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done && !empty_res && last |-> total_q == '0)
		else $error("last flag with items still stored");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_res |-> (sorted_value == '0) && !last)
		else $error("empty word carries data");
endmodule
`default_nettype wire

/* hdl/cse_ram.sv */
`default_nettype none
module cse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire
